[design/acl_pkg.sv]
// Shared types, constants and helper functions for the alarm code lock.
// Used by the step logic, the top level and the testbench; no dependencies.
package acl_pkg;

  localparam int MaxDigits   = 8;
  localparam int CountW      = $clog2(MaxDigits + 1);
  localparam int IdxW        = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  // The secret register holds eight two-bit digits at most.
  localparam int MatchDigits = (MaxDigits < 8) ? MaxDigits : 8;
  localparam int LenCmpW     = (CountW > 4) ? CountW : 4;

  localparam int TimerW  = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;
  localparam int SecsW   = 7;

  localparam logic [TimerW-1:0] TimerSat = '1;

  localparam logic [15:0] SecretCodeReset   = 16'd579;
  localparam logic [3:0]  SecretLengthReset = 4'd6;
  localparam logic [15:0] PassTimeoutReset  = 16'd5000;
  localparam logic [15:0] BlinkHalfReset    = 16'd150;

  // floor(x / 1000) = floor(floor(x / 8) * 8389 / 2^20) for every 16-bit x.
  localparam int          DivPreShift = 3;
  localparam int          DivShift    = 20;
  localparam logic [13:0] DivRecip    = 14'd8389;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSecretCode   = 2'd0,
    CfgSecretLength = 2'd1,
    CfgPassTimeout  = 2'd2,
    CfgBlinkHalf    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VerdictNone      = 2'd0,
    VerdictCorrect   = 2'd1,
    VerdictIncorrect = 2'd2
  } verdict_e;

  typedef enum logic {
    ReqTick = 1'b0,
    ReqKey  = 1'b1
  } req_type_e;

  typedef logic [1:0] digit_t;

  typedef struct packed {
    logic [15:0]       secret_code;
    logic [3:0]        secret_length;
    logic [TimerW-1:0] pass_timeout;
    logic [TimerW-1:0] blink_half;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [2:0] key_digit;
    logic       motion_level;
    logic       shock_level;
  } item_t;

  typedef struct packed {
    logic             alarm_on;
    logic             led_on;
    logic [3:0]       digits_entered;
    logic             entry_open;
    logic [1:0]       verdict;
    logic [SecsW-1:0] seconds_left;
  } result_t;

  typedef struct packed {
    logic              armed;
    logic              led_level;
    logic [TimerW-1:0] blink_elapsed;
    logic [CountW-1:0] entry_count;
    logic              entry_overflow;
    logic [TimerW-1:0] entry_elapsed;
    logic              prev_motion;
    logic              prev_shock;
  } state_t;

  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
    return (v == TimerSat) ? TimerSat : v + TimerW'(1);
  endfunction

  // A saturated timer counts as past any period.
  function automatic logic is_past(input logic [TimerW-1:0] elapsed,
                                   input logic [TimerW-1:0] period);
    return (elapsed == TimerSat) || (elapsed > period);
  endfunction

endpackage

[design/acl_ifs.sv]
// Valid/ready channel interfaces for the alarm code lock input and result words.
// Depends on nothing but plain logic signals.
interface acl_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [2:0] key_digit;
  logic       motion_level;
  logic       shock_level;

  modport source (output valid, req_type, key_digit, motion_level, shock_level,
                  input ready);
  modport sink   (input valid, req_type, key_digit, motion_level, shock_level,
                  output ready);
endinterface

interface acl_out_if;
  logic       valid;
  logic       ready;
  logic       alarm_on;
  logic       led_on;
  logic [3:0] digits_entered;
  logic       entry_open;
  logic [1:0] verdict;
  logic [6:0] seconds_left;

  modport source (output valid, alarm_on, led_on, digits_entered, entry_open, verdict,
                  seconds_left, input ready);
  modport sink   (input valid, alarm_on, led_on, digits_entered, entry_open, verdict,
                  seconds_left, output ready);
endinterface

[design/acl_step.sv]
// Combinational next-state and result logic for one word of the alarm code lock.
// Depends on acl_pkg.
module acl_step (
  input  acl_pkg::cfg_t                            cfg_i,
  input  acl_pkg::state_t                          state_i,
  input  acl_pkg::digit_t [acl_pkg::MaxDigits-1:0] digits_i,
  input  acl_pkg::item_t                           item_i,
  output acl_pkg::state_t                          state_o,
  output acl_pkg::digit_t [acl_pkg::MaxDigits-1:0] digits_o,
  output acl_pkg::result_t                         result_o
);

  acl_pkg::state_t                          st;
  acl_pkg::digit_t [acl_pkg::MaxDigits-1:0] dig;
  acl_pkg::verdict_e                        verdict;
  logic                                     open_pre;
  logic                                     open_post;
  logic                                     key_ok;
  logic                                     judge;
  logic                                     digits_ok;
  logic                                     match;
  logic [2:0]                               key_m1;
  logic [acl_pkg::TimerW-1:0]               remaining;
  logic [acl_pkg::TimerW-acl_pkg::DivPreShift-1:0] rem_div8;
  logic [26:0]                              prod;
  logic [acl_pkg::SecsW-1:0]                secs;

  always_comb begin
    st       = state_i;
    dig      = digits_i;
    verdict  = acl_pkg::VerdictNone;
    open_pre = (st.entry_count != '0) || st.entry_overflow;

    if (item_i.req_type == acl_pkg::ReqTick) begin
      st.blink_elapsed = acl_pkg::sat_inc(st.blink_elapsed);
      if (open_pre) begin
        st.entry_elapsed = acl_pkg::sat_inc(st.entry_elapsed);
      end
    end

    // The LED follows the armed state from before this word.
    if (state_i.armed) begin
      if (acl_pkg::is_past(st.blink_elapsed, cfg_i.blink_half)) begin
        st.blink_elapsed = '0;
        st.led_level     = !st.led_level;
      end
    end else begin
      st.led_level = 1'b0;
    end

    if ((item_i.motion_level != st.prev_motion) || (item_i.shock_level != st.prev_shock)) begin
      st.armed = 1'b1;
    end
    st.prev_motion = item_i.motion_level;
    st.prev_shock  = item_i.shock_level;

    key_ok = (item_i.req_type == acl_pkg::ReqKey) &&
             (item_i.key_digit >= 3'd1) && (item_i.key_digit <= 3'd4);
    key_m1 = item_i.key_digit - 3'd1;
    if (key_ok) begin
      if (st.entry_count < acl_pkg::CountW'(acl_pkg::MaxDigits)) begin
        dig[st.entry_count[acl_pkg::IdxW-1:0]] = key_m1[1:0];
        st.entry_count = st.entry_count + acl_pkg::CountW'(1);
      end else begin
        st.entry_overflow = 1'b1;
      end
      st.entry_elapsed = '0;
    end

    digits_ok = 1'b1;
    for (int i = 0; i < acl_pkg::MatchDigits; i++) begin
      if ((acl_pkg::LenCmpW'(i) < acl_pkg::LenCmpW'(st.entry_count)) &&
          (dig[i] != cfg_i.secret_code[2*i +: 2])) begin
        digits_ok = 1'b0;
      end
    end
    match = digits_ok && !st.entry_overflow && (st.entry_count != '0) &&
            (acl_pkg::LenCmpW'(st.entry_count) == acl_pkg::LenCmpW'(cfg_i.secret_length)) &&
            (acl_pkg::LenCmpW'(st.entry_count) <= acl_pkg::LenCmpW'(acl_pkg::MatchDigits));

    open_post = (st.entry_count != '0) || st.entry_overflow;
    judge     = open_post && acl_pkg::is_past(st.entry_elapsed, cfg_i.pass_timeout);
    if (judge) begin
      if (match) begin
        st.armed = 1'b0;
        verdict  = acl_pkg::VerdictCorrect;
      end else begin
        verdict  = acl_pkg::VerdictIncorrect;
      end
      st.entry_count    = '0;
      st.entry_overflow = 1'b0;
      st.entry_elapsed  = '0;
      open_post         = 1'b0;
    end

    remaining = cfg_i.pass_timeout - st.entry_elapsed;
    rem_div8  = remaining[acl_pkg::TimerW-1:acl_pkg::DivPreShift];
    prod      = 27'(rem_div8) * 27'(acl_pkg::DivRecip);
    if (open_post && (st.entry_elapsed <= cfg_i.pass_timeout)) begin
      secs = prod[acl_pkg::DivShift +: acl_pkg::SecsW];
    end else begin
      secs = '0;
    end
  end

  assign state_o  = st;
  assign digits_o = dig;

  assign result_o.alarm_on       = st.armed;
  assign result_o.led_on         = st.led_level;
  assign result_o.digits_entered = 4'(st.entry_count);
  assign result_o.entry_open     = open_post;
  assign result_o.verdict        = verdict;
  assign result_o.seconds_left   = secs;

endmodule

[design/alarm_code_lock.sv]
// Top level of the alarm code lock: channel registers, lock state and configuration.
// Depends on acl_pkg, acl_in_if, acl_out_if and acl_step.
//
//   channel   direction  word contents
//   in_i      sink       req_type, key_digit, motion_level, shock_level
//   out_o     source     alarm_on, led_on, digits_entered, entry_open, verdict,
//                        seconds_left
//   cfg_*     write      cfg_idx_i selects a register, cfg_wdata_i is its value
//
// A word accepted on in_i sits in the input register and goes through the step logic
// into the result register once that register is empty or being emptied, so a stalled
// sink can hold it there. A new word is accepted every cycle while the sink takes
// results; the lock state is fed back through the combinational step logic.
// Reset restores the default secret, timeout and blink period and clears the lock.
// When the result register is full and not taken, the input register takes one more
// word and then in_i.ready stays low until the sink takes the waiting result.
module alarm_code_lock (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  acl_in_if.sink                       in_i,
  acl_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [acl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [acl_pkg::CfgW-1:0]     cfg_wdata_i
);

  localparam acl_pkg::state_t StateReset = '{
    armed:          1'b0,
    led_level:      1'b0,
    blink_elapsed:  acl_pkg::TimerSat,
    entry_count:    '0,
    entry_overflow: 1'b0,
    entry_elapsed:  '0,
    prev_motion:    1'b0,
    prev_shock:     1'b0
  };

  acl_pkg::cfg_t                            cfg_q;
  acl_pkg::state_t                          state_q;
  acl_pkg::state_t                          state_d;
  acl_pkg::digit_t [acl_pkg::MaxDigits-1:0] digits_q;
  acl_pkg::digit_t [acl_pkg::MaxDigits-1:0] digits_d;
  acl_pkg::item_t                           in_item_q;
  acl_pkg::item_t                           in_item;
  logic                                     in_valid_q;
  acl_pkg::result_t                         out_q;
  acl_pkg::result_t                         out_d;
  logic                                     out_valid_q;
  logic                                     advance;
  logic                                     in_take;

  // A held word moves on when the result register is empty or being emptied.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  assign in_item.req_type     = in_i.req_type;
  assign in_item.key_digit    = in_i.key_digit;
  assign in_item.motion_level = in_i.motion_level;
  assign in_item.shock_level  = in_i.shock_level;

  // Configuration registers. Writes must arrive only while the lock is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.secret_code   <= acl_pkg::SecretCodeReset;
      cfg_q.secret_length <= acl_pkg::SecretLengthReset;
      cfg_q.pass_timeout  <= acl_pkg::PassTimeoutReset;
      cfg_q.blink_half    <= acl_pkg::BlinkHalfReset;
    end else if (cfg_we_i) begin
      unique case (acl_pkg::cfg_idx_e'(cfg_idx_i))
        acl_pkg::CfgSecretCode:   cfg_q.secret_code   <= cfg_wdata_i;
        acl_pkg::CfgSecretLength: cfg_q.secret_length <= cfg_wdata_i[3:0];
        acl_pkg::CfgPassTimeout:  cfg_q.pass_timeout  <= cfg_wdata_i;
        acl_pkg::CfgBlinkHalf:    cfg_q.blink_half    <= cfg_wdata_i;
      endcase
    end
  end

  // Input register: holds the accepted word until the step logic consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item;
    end
  end

  acl_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .digits_i (digits_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .digits_o (digits_d),
    .result_o (out_d)
  );

  // Lock state and the result valid flag advance together with each word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The digit store is only read below the entry count, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      digits_q <= digits_d;
      out_q    <= out_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.alarm_on       = out_q.alarm_on;
  assign out_o.led_on         = out_q.led_on;
  assign out_o.digits_entered = out_q.digits_entered;
  assign out_o.entry_open     = out_q.entry_open;
  assign out_o.verdict        = out_q.verdict;
  assign out_o.seconds_left   = out_q.seconds_left;

  // A correct code always leaves the alarm disarmed.
  a_correct_disarms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.verdict == acl_pkg::VerdictCorrect)) |-> !out_q.alarm_on)
    else $error("correct verdict with alarm still on");

  // A judged entry is closed and empty in the same result.
  a_verdict_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.verdict != acl_pkg::VerdictNone)) |->
    (!out_q.entry_open && (out_q.digits_entered == 4'd0)))
    else $error("verdict given while entry still open");

  // No countdown is shown without an open entry.
  a_closed_no_secs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.entry_open) |-> (out_q.seconds_left == '0))
    else $error("seconds left shown with entry closed");

  // A word blocked by a full result register stays in the input register.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_item_q)))
    else $error("blocked input word lost");

endmodule

[verif/alarm_code_lock_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for alarm_code_lock: directed scenarios, then random code entry.
// Depends on acl_pkg, acl_in_if, acl_out_if and the alarm_code_lock top level.
module alarm_code_lock_tb;
  import acl_pkg::*;

  // The slowest legal run stays well below this; it only catches a hung handshake.
  localparam int CycleLimit = 1_000_000;
  localparam int RandomWords = 550;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;

  acl_in_if in_ch ();
  acl_out_if out_ch ();

  alarm_code_lock i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Status words that the lock owes us, oldest first.
  result_t pending_status[$];
  int errors = 0;
  int words_sent = 0;
  int cycle_count = 0;

  // When quiet is set neither side idles; used for the long tick runs.
  bit quiet = 1'b0;
  int gap_pct = 0;
  int stall_pct = 0;

  // Sensor levels carried by every word we send.
  logic motion_lvl = 1'b0;
  logic shock_lvl = 1'b0;

  // Our own copy of the lock's registers and state.
  logic [15:0] code_r = SecretCodeReset;
  logic [3:0] len_r = SecretLengthReset;
  logic [15:0] timeout_r = PassTimeoutReset;
  logic [15:0] blink_r = BlinkHalfReset;

  logic armed_m = 1'b0;
  logic led_m = 1'b0;
  logic [15:0] blink_ms = 16'hFFFF;
  logic [15:0] entry_ms = 16'd0;
  digit_t entry_buf[MaxDigits];
  int entry_cnt = 0;
  logic entry_ovf = 1'b0;
  logic prev_mot = 1'b0;
  logic prev_shk = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Every input of the block gets a known value at time zero.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgSecretCode;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = ReqTick;
    in_ch.key_digit = 3'd0;
    in_ch.motion_level = 1'b0;
    in_ch.shock_level = 1'b0;
  end

  // Timers stick at all ones.
  function automatic logic [15:0] timer_tick(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // A stuck timer counts as expired whatever the period.
  function automatic logic timer_expired(input logic [15:0] elapsed, input logic [15:0] period);
    return (elapsed == 16'hFFFF) || (elapsed > period);
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Chooses how busy one side is for the next stretch; zero gives a stretch with no idling.
  function automatic int stretch_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // Advances the lock by one word and returns the status it should report. The order
  // matters: tick, LED step on the old armed state, sensors, key, then judgement.
  function automatic result_t step_lock(input item_t w);
    result_t r;
    logic is_key;
    logic open;
    logic match;
    verdict_e verdict;
    is_key = (w.req_type == ReqKey);
    open = (entry_cnt != 0) || entry_ovf;
    if (!is_key) begin
      blink_ms = timer_tick(blink_ms);
      if (open) entry_ms = timer_tick(entry_ms);
    end
    if (armed_m) begin
      if (timer_expired(blink_ms, blink_r)) begin
        blink_ms = 16'd0;
        led_m = ~led_m;
      end
    end else begin
      led_m = 1'b0;
    end
    if (w.motion_level != prev_mot || w.shock_level != prev_shk) armed_m = 1'b1;
    prev_mot = w.motion_level;
    prev_shk = w.shock_level;
    // Keys outside 1..4 neither add a digit nor restart the entry timer.
    if (is_key && w.key_digit >= 3'd1 && w.key_digit <= 3'd4) begin
      if (entry_cnt < MaxDigits) begin
        entry_buf[entry_cnt] = digit_t'(w.key_digit - 3'd1);
        entry_cnt++;
      end else begin
        entry_ovf = 1'b1;
      end
      entry_ms = 16'd0;
    end
    open = (entry_cnt != 0) || entry_ovf;
    verdict = VerdictNone;
    if (open && timer_expired(entry_ms, timeout_r)) begin
      // An overflowed entry, or a secret length the store cannot hold, never matches.
      match = !entry_ovf && (entry_cnt == int'(len_r)) && (entry_cnt != 0) && (entry_cnt <= 8);
      for (int i = 0; i < entry_cnt; i++) begin
        if (entry_buf[i] != code_r[2*i +: 2]) match = 1'b0;
      end
      if (match) begin
        armed_m = 1'b0;
        verdict = VerdictCorrect;
      end else begin
        verdict = VerdictIncorrect;
      end
      entry_cnt = 0;
      entry_ovf = 1'b0;
      entry_ms = 16'd0;
      open = 1'b0;
    end
    r.alarm_on = armed_m;
    r.led_on = led_m;
    r.digits_entered = 4'(entry_cnt);
    r.entry_open = open;
    r.verdict = verdict;
    r.seconds_left = '0;
    if (open && entry_ms <= timeout_r) r.seconds_left = SecsW'((timeout_r - entry_ms) / 16'd1000);
    return r;
  endfunction

  // Drives one word from a falling edge and returns on the falling edge after it is taken.
  // Valid stays high on return so that a word sent right after keeps it high without a dip.
  task automatic send_word(input item_t w);
    int gap;
    gap = 0;
    if (!quiet && ($urandom_range(99) < gap_pct)) gap = idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= w.req_type;
    in_ch.key_digit <= w.key_digit;
    in_ch.motion_level <= w.motion_level;
    in_ch.shock_level <= w.shock_level;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_status.push_back(step_lock(w));
    words_sent++;
    if (words_sent % 64 == 0) gap_pct = stretch_pct();
    @(negedge clk_i);
  endtask

  task automatic press(input logic [2:0] d);
    item_t w;
    w.req_type = ReqKey;
    w.key_digit = d;
    w.motion_level = motion_lvl;
    w.shock_level = shock_lvl;
    send_word(w);
  endtask

  // The key field of a tick is ignored, so it is filled with noise.
  task automatic ticks(input int n);
    item_t w;
    repeat (n) begin
      w.req_type = ReqTick;
      w.key_digit = 3'($urandom_range(7));
      w.motion_level = motion_lvl;
      w.shock_level = shock_lvl;
      send_word(w);
    end
  endtask

  // A change on motion, shock or both arms the lock with the next word.
  task automatic flip_sensor();
    case ($urandom_range(2))
      0: motion_lvl = ~motion_lvl;
      1: shock_lvl = ~shock_lvl;
      default: begin
        motion_lvl = ~motion_lvl;
        shock_lvl = ~shock_lvl;
      end
    endcase
  endtask

  // Lowers valid and waits until every status word has come back, plus the input and
  // result registers and some margin, so that nothing is in flight inside the block.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgSecretCode: code_r = value;
      CfgSecretLength: len_r = value[3:0];
      CfgPassTimeout: timeout_r = value;
      default: blink_r = value;
    endcase
  endtask

  task automatic set_config(input logic [15:0] code, input logic [3:0] len,
                            input logic [15:0] timeout, input logic [15:0] blink);
    write_reg(CfgSecretCode, code);
    write_reg(CfgSecretLength, {12'd0, len});
    write_reg(CfgPassTimeout, timeout);
    write_reg(CfgBlinkHalf, blink);
  endtask

  // Digit i of the current secret as a key number; indexes past eight wrap around.
  function automatic logic [2:0] secret_key(input int i);
    return 3'(code_r[2*(i%8) +: 2]) + 3'd1;
  endfunction

  // Enter the reset secret 4 1 1 2 3 1 under the reset timeout, see the seconds count
  // start at five, then shorten the timeout so the next tick judges the stored entry.
  task automatic test_reset_defaults();
    ticks(1);
    flip_sensor();
    ticks(1);
    for (int i = 0; i < 6; i++) press(secret_key(i));
    ticks(2);
    write_reg(CfgPassTimeout, 16'd0);
    ticks(2);
  endtask

  // Zero periods: the LED toggles on every armed tick and an entry closes on the
  // first tick after its last key.
  task automatic test_zero_periods();
    set_config(16'h0000, 4'd1, 16'd0, 16'd0);
    flip_sensor();
    ticks(3);
    press(3'd1);
    ticks(1);
    press(3'd2);
    press(3'd3);
    ticks(2);
  endtask

  // Keys 0 and 5..7 add nothing and leave the entry timer running.
  task automatic test_bad_keys();
    set_config(16'h00E4, 4'd4, 16'd3, 16'd2);
    press(3'd0);
    press(3'd1);
    ticks(2);
    press(3'd5);
    ticks(1);
    press(3'd6);
    ticks(1);
    for (int i = 0; i < 4; i++) begin
      press(3'(i + 1));
      press(3'd7);
    end
    ticks(4);
  endtask

  // A ninth digit is dropped but marks the entry as overflowed, which never matches.
  task automatic test_overflow();
    set_config(16'hFFFF, 4'd8, 16'd2, 16'd1);
    repeat (9) press(3'd4);
    ticks(3);
    repeat (8) press(3'd4);
    ticks(3);
  endtask

  // Secret lengths of zero and above eight never match; lengths one and eight can.
  task automatic test_length_extremes();
    set_config(16'h0000, 4'd0, 16'd1, 16'd3);
    press(3'd1);
    ticks(2);
    set_config(16'h0000, 4'd15, 16'd1, 16'd3);
    repeat (8) press(3'd1);
    ticks(2);
    set_config(16'h0000, 4'd9, 16'd1, 16'd3);
    repeat (8) press(3'd1);
    ticks(2);
    set_config(16'h1B6C, 4'd8, 16'd1, 16'd3);
    for (int i = 0; i < 8; i++) press(secret_key(i));
    ticks(2);
  endtask

  // A verdict comes out even while the alarm is off: wrong gives incorrect, right
  // gives correct and the alarm stays off.
  task automatic test_unarmed_verdict();
    set_config(16'h0006, 4'd2, 16'd2, 16'd5);
    press(3'd3);
    press(3'd1);
    ticks(3);
    press(3'd3);
    press(3'd2);
    ticks(3);
  endtask

  // Disarming while the LED is lit leaves it lit until the following word.
  task automatic test_disarm_led();
    set_config(16'h0000, 4'd1, 16'd1, 16'd0);
    flip_sensor();
    ticks(1);
    press(3'd1);
    ticks(2);
    ticks(2);
  endtask

  // With both periods at their top value nothing expires in a short run, and the
  // seconds count starts from its largest value.
  task automatic test_saturated_timers();
    set_config(16'h0000, 4'd1, 16'hFFFF, 16'hFFFF);
    quiet = 1'b1;
    flip_sensor();
    press(3'd1);
    ticks(100);
    quiet = 1'b0;
  endtask

  // Mostly well-formed code entries with random content, some with a wrong digit, a
  // wrong length or too many digits, sprinkled with sensor changes, pauses no longer than
  // the timeout and dead keys, plus stretches of pure noise.
  task automatic test_random();
    int first;
    int r;
    int n;
    int wrong;
    int k;
    logic [2:0] d;
    item_t w;
    first = words_sent;
    while (words_sent - first < RandomWords) begin
      // The first pass always loads a new configuration; its timeout is always short.
      if ((words_sent == first) || ($urandom_range(3) == 0)) begin
        set_config(16'($urandom_range(16'hFFFF)),
                   ($urandom_range(99) < 85) ? 4'($urandom_range(1, 8))
                     : (($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(9, 15))),
                   16'($urandom_range(0, 12)),
                   ($urandom_range(99) < 80) ? 16'($urandom_range(0, 8))
                     : 16'($urandom_range(16'hFFFF)));
      end
      if ($urandom_range(99) < 40) flip_sensor();
      r = $urandom_range(99);
      if (r >= 88) begin
        repeat ($urandom_range(5, 15)) begin
          w = item_t'($urandom_range(63));
          motion_lvl = w.motion_level;
          shock_lvl = w.shock_level;
          send_word(w);
        end
      end else begin
        n = (len_r >= 4'd1 && len_r <= 4'd8) ? int'(len_r) : $urandom_range(1, 8);
        if (r >= 80) n = $urandom_range(9, 11);
        else if (r >= 70) n = (n > 1 && $urandom_range(1) == 0) ? n - 1 : n + 1;
        wrong = (r >= 55 && r < 70) ? $urandom_range(n - 1) : -1;
        for (int i = 0; i < n; i++) begin
          d = secret_key(i);
          if (i == wrong) d = 3'((d % 4) + 1);
          press(d);
          k = $urandom_range(99);
          if (k < 15) ticks($urandom_range(0, timeout_r));
          else if (k < 22) press(($urandom_range(3) == 0) ? 3'd0 : 3'($urandom_range(5, 7)));
          else if (k < 28) flip_sensor();
        end
        ticks(timeout_r + 1 + $urandom_range(0, 3));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result checker: every taken status word is matched against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        $error("status word arrived with none expected");
        errors++;
      end else begin
        want = pending_status.pop_front();
        check_field("alarm_on", 16'(want.alarm_on), 16'(out_ch.alarm_on));
        check_field("led_on", 16'(want.led_on), 16'(out_ch.led_on));
        check_field("digits_entered", 16'(want.digits_entered), 16'(out_ch.digits_entered));
        check_field("entry_open", 16'(want.entry_open), 16'(out_ch.entry_open));
        check_field("verdict", 16'(want.verdict), 16'(out_ch.verdict));
        check_field("seconds_left", 16'(want.seconds_left), 16'(out_ch.seconds_left));
      end
    end
  end

  // Result side back-pressure: random stalls in stretches of varying density.
  initial begin
    int stall_left;
    int since;
    stall_left = 0;
    since = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      since++;
      if (since % 64 == 0) stall_pct = stretch_pct();
      if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(99) < stall_pct) stall_left = idle_length();
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("alarm_code_lock verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_zero_periods();
    test_bad_keys();
    test_overflow();
    test_length_extremes();
    test_unarmed_verdict();
    test_disarm_led();
    test_saturated_timers();
    test_random();
    drain();
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("alarm_code_lock verification clean");
    end else begin
      $display("alarm_code_lock verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/acl_pkg.sv
design/acl_ifs.sv
design/acl_step.sv
design/alarm_code_lock.sv
verif/alarm_code_lock_tb.sv
